// ----- rtl/led_pkg.sv -----
// ----------------------------------------------------------------------------
// led_pkg
// Shared types, constants and helpers for the line edit buffer.
// ----------------------------------------------------------------------------
package led_pkg;

    localparam int BUF_LEN = 256;
    localparam int ADDR_W  = $clog2(BUF_LEN);
    localparam int POS_W   = ADDR_W + 1;
    localparam int SUM_W   = POS_W + 1;

    // command opcodes
    typedef enum logic [3:0] {
        OP_INSERT     = 4'd0,
        OP_RIGHT      = 4'd1,
        OP_LEFT       = 4'd2,
        OP_WORD_RIGHT = 4'd3,
        OP_WORD_LEFT  = 4'd4,
        OP_DELETE     = 4'd5,
        OP_BACKSPACE  = 4'd6,
        OP_BACK_WORD  = 4'd7,
        OP_KILL_END   = 4'd8,
        OP_KILL_START = 4'd9,
        OP_HOME       = 4'd10,
        OP_END        = 4'd11,
        OP_READ       = 4'd12
    } op_t;

    // datapath micro-commands, one per cycle
    typedef enum logic [4:0] {
        C_NOP,
        C_LOAD,
        C_INIT,
        C_REFUSE,
        C_INS_INIT,
        C_RD_IDXM1,
        C_WR_IDX_DEC,
        C_INS_PUT,
        C_CUR_DEC_SAT,
        C_CUR_DEC,
        C_CUR_INC_SAT,
        C_CUR_INC,
        C_RD_CUR,
        C_RD_CURM1,
        C_DEL_INIT,
        C_RD_CURN,
        C_N_INC,
        C_IDX_CUR,
        C_RD_IDXN,
        C_WR_IDX_INC,
        C_LEN_SUBN,
        C_SET_STOP,
        C_CUR_INC_F,
        C_CUR_DEC_F,
        C_RD_RI,
        C_CAP_READ,
        C_KILL_END,
        C_HOME,
        C_END,
        C_PUBLISH
    } cmd_t;

    // sequencer states
    typedef enum logic [4:0] {
        S_IDLE, S_DISPATCH, S_DONE,
        S_INS, S_INS_RD, S_INS_WR,
        S_SL, S_SL_RD, S_SL_CHK,
        S_SR, S_SR_RD, S_SR_CHK,
        S_DEL, S_DEL_NRD, S_DEL_NCHK, S_DEL_CRD, S_DEL_CWR,
        S_BW, S_BW_STOP, S_BW_SCHK,
        S_WR, S_WR_TCHK, S_WR_BODY, S_WR_MRD, S_WR_MCHK,
        S_WL, S_WL_TCHK, S_WL_BODY, S_WL_MRD, S_WL_MCHK,
        S_RD_CAP
    } state_t;

    // status from datapath to controller
    typedef struct packed {
        op_t  op;
        logic cur_gt0;
        logic cur_lt_len;
        logic full;
        logic idx_gt_cur;
        logic curn_lt_len;
        logic idxn_lt_len;
        logic ri_lt_len;
        logic rmark;
        logic rterm;
        logic first;
        logic stop;
        logic wm;
        logic out_busy;
    } status_t;

    // word terminators: '/', '&', '?', space
    function automatic logic is_term(input logic [7:0] c);
        return (c == 8'h2F) || (c == 8'h26) || (c == 8'h3F) || (c == 8'h20);
    endfunction

endpackage

// ----- rtl/led_datapath.sv -----
// ----------------------------------------------------------------------------
// led_datapath
// Byte store with marks, cursor, length, scan pointers and result register.
// ----------------------------------------------------------------------------
module led_datapath
    import led_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  cmd_t              cmd,
    output status_t           status,
    input  logic              cfg_we,
    input  logic              cfg_data,
    input  logic [3:0]        opcode,
    input  logic [7:0]        data_byte,
    input  logic              is_continuation,
    input  logic [7:0]        read_index,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [POS_W-1:0]  cursor_pos,
    output logic [POS_W-1:0]  line_length,
    output logic [7:0]        read_byte,
    output logic              read_mark,
    output logic              insert_refused
);

    // store: {mark, byte}
    logic [8:0]        mem [BUF_LEN];
    logic [8:0]        rdata_reg;
    logic [ADDR_W-1:0] ra;
    logic [ADDR_W-1:0] wa;
    logic [8:0]        wd;
    logic              we;

    logic [POS_W-1:0]  cur_reg, cur_next;
    logic [POS_W-1:0]  len_reg, len_next;
    logic [POS_W-1:0]  idx_reg, idx_next;
    logic [POS_W-1:0]  n_reg, n_next;
    logic              first_reg, first_next;
    logic              stop_reg, stop_next;
    logic              wm_reg;
    op_t               op_reg;
    logic [7:0]        db_reg;
    logic              mk_reg;
    logic [7:0]        ri_reg;
    logic [7:0]        rb_reg, rb_next;
    logic              rm_reg, rm_next;
    logic              ref_reg, ref_next;
    logic              ov_reg;
    logic [POS_W-1:0]  ocur_reg;
    logic [POS_W-1:0]  olen_reg;
    logic [7:0]        orb_reg;
    logic              orm_reg;
    logic              oref_reg;

    logic [SUM_W-1:0]  cur_n;
    logic [SUM_W-1:0]  idx_n;

    assign cur_n = SUM_W'(cur_reg) + SUM_W'(n_reg);
    assign idx_n = SUM_W'(idx_reg) + SUM_W'(n_reg);

    // status
    always_comb
    begin
        status.op          = op_reg;
        status.cur_gt0     = (cur_reg != '0);
        status.cur_lt_len  = (cur_reg < len_reg);
        status.full        = (len_reg >= POS_W'(BUF_LEN));
        status.idx_gt_cur  = (idx_reg > cur_reg);
        status.curn_lt_len = (cur_n < SUM_W'(len_reg));
        status.idxn_lt_len = (idx_n < SUM_W'(len_reg));
        status.ri_lt_len   = (POS_W'(ri_reg) < len_reg);
        status.rmark       = rdata_reg[8];
        status.rterm       = is_term(rdata_reg[7:0]);
        status.first       = first_reg;
        status.stop        = stop_reg;
        status.wm          = wm_reg;
        status.out_busy    = ov_reg && !out_ready;
    end

    // memory addressing and register updates
    always_comb
    begin
        ra         = cur_reg[ADDR_W-1:0];
        wa         = idx_reg[ADDR_W-1:0];
        wd         = rdata_reg;
        we         = 1'b0;
        cur_next   = cur_reg;
        len_next   = len_reg;
        idx_next   = idx_reg;
        n_next     = n_reg;
        first_next = first_reg;
        stop_next  = stop_reg;
        rb_next    = rb_reg;
        rm_next    = rm_reg;
        ref_next   = ref_reg;
        unique case (cmd)
            C_LOAD:
            begin
                rb_next  = '0;
                rm_next  = 1'b0;
                ref_next = 1'b0;
            end
            C_INIT:
            begin
                first_next = 1'b1;
                stop_next  = 1'b0;
            end
            C_REFUSE:      ref_next = 1'b1;
            C_INS_INIT:    idx_next = len_reg;
            C_RD_IDXM1:    ra = idx_reg[ADDR_W-1:0] - ADDR_W'(1);
            C_WR_IDX_DEC:
            begin
                we       = 1'b1;
                idx_next = idx_reg - POS_W'(1);
            end
            C_INS_PUT:
            begin
                we       = 1'b1;
                wa       = cur_reg[ADDR_W-1:0];
                wd       = {mk_reg, db_reg};
                cur_next = cur_reg + POS_W'(1);
                len_next = len_reg + POS_W'(1);
            end
            C_CUR_DEC_SAT: if (cur_reg != '0) cur_next = cur_reg - POS_W'(1);
            C_CUR_DEC:     cur_next = cur_reg - POS_W'(1);
            C_CUR_INC_SAT: if (cur_reg < len_reg) cur_next = cur_reg + POS_W'(1);
            C_CUR_INC:     cur_next = cur_reg + POS_W'(1);
            C_RD_CUR:      ra = cur_reg[ADDR_W-1:0];
            C_RD_CURM1:    ra = cur_reg[ADDR_W-1:0] - ADDR_W'(1);
            C_DEL_INIT:    n_next = POS_W'(1);
            C_RD_CURN:     ra = cur_n[ADDR_W-1:0];
            C_N_INC:       n_next = n_reg + POS_W'(1);
            C_IDX_CUR:     idx_next = cur_reg;
            C_RD_IDXN:     ra = idx_n[ADDR_W-1:0];
            C_WR_IDX_INC:
            begin
                we       = 1'b1;
                idx_next = idx_reg + POS_W'(1);
            end
            C_LEN_SUBN:    len_next = len_reg - n_reg;
            C_SET_STOP:    stop_next = is_term(rdata_reg[7:0]);
            C_CUR_INC_F:
            begin
                cur_next   = cur_reg + POS_W'(1);
                first_next = 1'b0;
            end
            C_CUR_DEC_F:
            begin
                cur_next   = cur_reg - POS_W'(1);
                first_next = 1'b0;
            end
            C_RD_RI:       ra = ri_reg[ADDR_W-1:0];
            C_CAP_READ:
            begin
                rb_next = rdata_reg[7:0];
                rm_next = rdata_reg[8];
            end
            C_KILL_END:    len_next = cur_reg;
            C_HOME:        cur_next = '0;
            C_END:         cur_next = len_reg;
            default:       ;
        endcase
    end

    // store
    always_ff @(posedge clk)
    begin
        if (we)
            mem[wa] <= wd;
        rdata_reg <= mem[ra];
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        n_reg   <= n_next;
        rb_reg  <= rb_next;
        rm_reg  <= rm_next;
        ref_reg <= ref_next;
        if (cmd == C_LOAD)
        begin
            op_reg <= op_t'(opcode);
            db_reg <= data_byte;
            mk_reg <= is_continuation;
            ri_reg <= read_index;
        end
        if (cmd == C_PUBLISH)
        begin
            ocur_reg <= cur_reg;
            olen_reg <= len_reg;
            orb_reg  <= rb_reg;
            orm_reg  <= rm_reg;
            oref_reg <= ref_reg;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_reg   <= '0;
            len_reg   <= '0;
            first_reg <= 1'b0;
            stop_reg  <= 1'b0;
            wm_reg    <= 1'b1;
            ov_reg    <= 1'b0;
        end
        else
        begin
            cur_reg   <= cur_next;
            len_reg   <= len_next;
            first_reg <= first_next;
            stop_reg  <= stop_next;
            if (cfg_we)
                wm_reg <= cfg_data;
            if (cmd == C_PUBLISH)
                ov_reg <= 1'b1;
            else if (out_ready)
                ov_reg <= 1'b0;
        end
    end

    assign out_valid      = ov_reg;
    assign cursor_pos     = ocur_reg;
    assign line_length    = olen_reg;
    assign read_byte      = orb_reg;
    assign read_mark      = orm_reg;
    assign insert_refused = oref_reg;

endmodule

// ----- rtl/led_ctrl.sv -----
// ----------------------------------------------------------------------------
// led_ctrl
// Sequencer: steps each command through reads, shifts and scans.
// ----------------------------------------------------------------------------
module led_ctrl
    import led_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    input  status_t status,
    output cmd_t    cmd
);

    state_t state_reg, state_next;
    state_t after_sl;
    state_t after_del;
    state_t wr_loop;
    state_t wl_loop;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    // return points of the shared step-left and delete sequences, and the word-move loop points
    always_comb
    begin
        after_sl  = (status.op == OP_LEFT) ? S_DONE :
                    (status.op == OP_BACKSPACE) ? S_DEL : S_BW_STOP;
        after_del = (status.op == OP_BACK_WORD || status.op == OP_KILL_START) ?
                    S_BW : S_DONE;
        wr_loop   = status.wm ? S_WR : S_DONE;
        wl_loop   = status.wm ? S_WL : S_DONE;
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = C_NOP;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd        = C_LOAD;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                cmd = C_INIT;
                case (status.op)
                    OP_INSERT:     state_next = S_INS;
                    OP_RIGHT:      state_next = S_SR;
                    OP_LEFT:       state_next = S_SL;
                    OP_WORD_RIGHT: state_next = S_WR;
                    OP_WORD_LEFT:  state_next = S_WL;
                    OP_DELETE:     state_next = S_DEL;
                    OP_BACKSPACE:  state_next = status.cur_gt0 ? S_SL : S_DONE;
                    OP_BACK_WORD, OP_KILL_START: state_next = S_BW;
                    OP_KILL_END:
                    begin
                        cmd        = C_KILL_END;
                        state_next = S_DONE;
                    end
                    OP_HOME:
                    begin
                        cmd        = C_HOME;
                        state_next = S_DONE;
                    end
                    OP_END:
                    begin
                        cmd        = C_END;
                        state_next = S_DONE;
                    end
                    OP_READ:
                    begin
                        if (status.ri_lt_len)
                        begin
                            cmd        = C_RD_RI;
                            state_next = S_RD_CAP;
                        end
                        else
                            state_next = S_DONE;
                    end
                    default: state_next = S_DONE;
                endcase
            end
            S_RD_CAP:
            begin
                cmd        = C_CAP_READ;
                state_next = S_DONE;
            end
            // insert: refused when full; else shift tail up one place, then write at the cursor
            S_INS:
            begin
                if (status.full)
                begin
                    cmd        = C_REFUSE;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd        = C_INS_INIT;
                    state_next = S_INS_RD;
                end
            end
            S_INS_RD:
            begin
                if (status.idx_gt_cur)
                begin
                    cmd        = C_RD_IDXM1;
                    state_next = S_INS_WR;
                end
                else
                begin
                    cmd        = C_INS_PUT;
                    state_next = S_DONE;
                end
            end
            S_INS_WR:
            begin
                cmd        = C_WR_IDX_DEC;
                state_next = S_INS_RD;
            end
            // one character left
            S_SL:
            begin
                cmd        = C_CUR_DEC_SAT;
                state_next = S_SL_RD;
            end
            S_SL_RD:
            begin
                if (status.cur_gt0)
                begin
                    cmd        = C_RD_CUR;
                    state_next = S_SL_CHK;
                end
                else
                    state_next = after_sl;
            end
            S_SL_CHK:
            begin
                if (status.rmark)
                begin
                    cmd        = C_CUR_DEC;
                    state_next = S_SL_RD;
                end
                else
                    state_next = after_sl;
            end
            // one character right
            S_SR:
            begin
                cmd        = C_CUR_INC_SAT;
                state_next = S_SR_RD;
            end
            S_SR_RD:
            begin
                if (status.cur_lt_len)
                begin
                    cmd        = C_RD_CUR;
                    state_next = S_SR_CHK;
                end
                else
                    state_next = S_DONE;
            end
            S_SR_CHK:
            begin
                if (status.rmark)
                begin
                    cmd        = C_CUR_INC;
                    state_next = S_SR_RD;
                end
                else
                    state_next = S_DONE;
            end
            // delete at cursor: count the character, then shift tail down
            S_DEL:
            begin
                if (status.cur_lt_len)
                begin
                    cmd        = C_DEL_INIT;
                    state_next = S_DEL_NRD;
                end
                else
                    state_next = after_del;
            end
            S_DEL_NRD:
            begin
                if (status.curn_lt_len)
                begin
                    cmd        = C_RD_CURN;
                    state_next = S_DEL_NCHK;
                end
                else
                begin
                    cmd        = C_IDX_CUR;
                    state_next = S_DEL_CRD;
                end
            end
            S_DEL_NCHK:
            begin
                if (status.rmark)
                begin
                    cmd        = C_N_INC;
                    state_next = S_DEL_NRD;
                end
                else
                begin
                    cmd        = C_IDX_CUR;
                    state_next = S_DEL_CRD;
                end
            end
            S_DEL_CRD:
            begin
                if (status.idxn_lt_len)
                begin
                    cmd        = C_RD_IDXN;
                    state_next = S_DEL_CWR;
                end
                else
                begin
                    cmd        = C_LEN_SUBN;
                    state_next = after_del;
                end
            end
            S_DEL_CWR:
            begin
                cmd        = C_WR_IDX_INC;
                state_next = S_DEL_CRD;
            end
            // backspace word / kill to start loop
            S_BW:
            begin
                if (status.cur_gt0 && !status.stop)
                    state_next = S_SL;
                else
                    state_next = S_DONE;
            end
            S_BW_STOP:
            begin
                if (status.op == OP_BACK_WORD && status.wm && status.cur_gt0)
                begin
                    cmd        = C_RD_CURM1;
                    state_next = S_BW_SCHK;
                end
                else
                    state_next = S_DEL;
            end
            S_BW_SCHK:
            begin
                cmd        = C_SET_STOP;
                state_next = S_DEL;
            end
            // word right
            S_WR:
            begin
                if (!status.cur_lt_len)
                    state_next = S_DONE;
                else if (status.first)
                    state_next = S_WR_BODY;
                else
                begin
                    cmd        = C_RD_CURM1;
                    state_next = S_WR_TCHK;
                end
            end
            S_WR_TCHK: state_next = status.rterm ? S_DONE : S_WR_BODY;
            S_WR_BODY:
            begin
                cmd        = C_CUR_INC_F;
                state_next = S_WR_MRD;
            end
            S_WR_MRD:
            begin
                if (status.cur_lt_len)
                begin
                    cmd        = C_RD_CUR;
                    state_next = S_WR_MCHK;
                end
                else
                    state_next = wr_loop;
            end
            S_WR_MCHK:
            begin
                if (status.rmark)
                    cmd = C_CUR_INC;
                state_next = wr_loop;
            end
            // word left
            S_WL:
            begin
                if (!status.cur_gt0)
                    state_next = S_DONE;
                else if (status.first)
                    state_next = S_WL_BODY;
                else
                begin
                    cmd        = C_RD_CURM1;
                    state_next = S_WL_TCHK;
                end
            end
            S_WL_TCHK: state_next = status.rterm ? S_DONE : S_WL_BODY;
            S_WL_BODY:
            begin
                cmd        = C_CUR_DEC_F;
                state_next = S_WL_MRD;
            end
            S_WL_MRD:
            begin
                if (status.cur_gt0)
                begin
                    cmd        = C_RD_CUR;
                    state_next = S_WL_MCHK;
                end
                else
                    state_next = wl_loop;
            end
            S_WL_MCHK:
            begin
                if (status.rmark)
                    cmd = C_CUR_DEC;
                state_next = wl_loop;
            end
            // hand the result to the output register
            S_DONE:
            begin
                if (!status.out_busy)
                begin
                    cmd        = C_PUBLISH;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

endmodule

// ----- rtl/line_edit_buffer_core.sv -----
// ----------------------------------------------------------------------------
// line_edit_buffer_core
// Line editing buffer of 256 bytes with continuation marks, cursor and length.
// ----------------------------------------------------------------------------
// One request is handled at a time. Every memory access goes through the byte
// store, which has one read port with a registered read and one write port, so
// each inspected or moved byte needs a read step before it is checked or written.
// Home, end, kill to end and unused codes need no store access; a read needs one;
// a character move steps once per byte crossed; insert moves every byte from the
// cursor to the end; delete reads the character's bytes and moves every byte behind
// it; word moves step character by character; backspace word and kill to start
// repeat a backspace per character. A finished result is held in an output
// register, so the next request is taken while it waits. word_moves is written
// through the cfg channel, which is always ready.
module line_edit_buffer_core
    import led_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic             cfg_data,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [3:0]       opcode,
    input  logic [7:0]       data_byte,
    input  logic             is_continuation,
    input  logic [7:0]       read_index,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [POS_W-1:0] cursor_pos,
    output logic [POS_W-1:0] line_length,
    output logic [7:0]       read_byte,
    output logic             read_mark,
    output logic             insert_refused
);

    cmd_t    cmd;
    status_t status;

    assign cfg_ready = 1'b1;

    // sequencer
    led_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    // store and registers
    led_datapath u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .cfg_we          (cfg_valid),
        .cfg_data        (cfg_data),
        .opcode          (opcode),
        .data_byte       (data_byte),
        .is_continuation (is_continuation),
        .read_index      (read_index),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .cursor_pos      (cursor_pos),
        .line_length     (line_length),
        .read_byte       (read_byte),
        .read_mark       (read_mark),
        .insert_refused  (insert_refused)
    );

endmodule
